FILE: design/i2cbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-bang sequencer package
// Shared constants, command and pin codes, and the structs that travel
// between the front end, the command queue and the pin sequencer.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

   localparam int BITS_PER_BYTE  = 8;
   localparam int DELAY_WIDTH    = 16;
   localparam int FUNC_WIDTH     = 4;
   localparam int DATA_WIDTH     = 8;
   localparam int DATA_IDX_WIDTH = $clog2(DATA_WIDTH);
   localparam int BIT_CNT_WIDTH  =
      ($clog2(BITS_PER_BYTE + 1) > DATA_IDX_WIDTH + 1) ?
      $clog2(BITS_PER_BYTE + 1) : DATA_IDX_WIDTH + 1;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_WIDTH     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [FUNC_WIDTH-1:0] {
      OP_NONE     = 4'd0,
      OP_IDLE     = 4'd1,
      OP_START    = 4'd2,
      OP_STOP     = 4'd3,
      OP_SENDBYTE = 4'd4,
      OP_RECVBYTE = 4'd5,
      OP_SENDBIT  = 4'd6,
      OP_RECVBIT  = 4'd7,
      OP_ACK      = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      SDA_LOW  = 2'd0,
      SDA_HIGH = 2'd1,
      SDA_REL  = 2'd2
   } sda_type;

   typedef struct packed {
      logic    scl;
      sda_type sda;
   } pin_type;

   // One classified tick as it waits in the queue.
   typedef struct packed {
      op_type                op;
      logic [DATA_WIDTH-1:0] shift_init;
      logic                  sda_in;
   } cmd_type;

   typedef struct packed {
      logic                  scl_out;
      logic [1:0]            sda_mode;
      logic                  busy_res;
      logic                  done_res;
      logic [DATA_WIDTH-1:0] read_data;
   } rsp_type;

endpackage

FILE: design/i2cbb_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-bang request channel
// Valid/ready channel that carries one sequencer tick with its command.
// ----------------------------------------------------------------------------
interface i2cbb_req_if import i2cbb_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [FUNC_WIDTH-1:0] func;
   logic [DATA_WIDTH-1:0] data_byte;
   logic                  sda_in;

   modport source (output valid, output func, output data_byte, output sda_in,
                   input ready);
   modport sink   (input valid, input func, input data_byte, input sda_in,
                   output ready);

endinterface

FILE: design/i2cbb_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-bang response channel
// Valid/ready channel that carries the pin levels and status of one tick.
// ----------------------------------------------------------------------------
interface i2cbb_rsp_if import i2cbb_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic                  scl_out;
   logic [1:0]            sda_mode;
   logic                  busy_res;
   logic                  done_res;
   logic [DATA_WIDTH-1:0] read_data;

   modport source (output valid, output scl_out, output sda_mode, output busy_res,
                   output done_res, output read_data, input ready);
   modport sink   (input valid, input scl_out, input sda_mode, input busy_res,
                   input done_res, input read_data, output ready);

endinterface

FILE: design/i2cbb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-bang front end
// Decodes the function code of each incoming tick and prepares the initial
// shift register contents before the tick is queued.
// ----------------------------------------------------------------------------
module i2cbb_front import i2cbb_pkg::*; (
   i2cbb_req_if.sink req_if,
   output cmd_type   cmd,
   output logic      cmd_valid,
   input  logic      cmd_ready
);

   op_type op;

   always_comb begin
      unique case (op_type'(req_if.func))
         OP_IDLE:     op = OP_IDLE;
         OP_START:    op = OP_START;
         OP_STOP:     op = OP_STOP;
         OP_SENDBYTE: op = OP_SENDBYTE;
         OP_RECVBYTE: op = OP_RECVBYTE;
         OP_SENDBIT:  op = OP_SENDBIT;
         OP_RECVBIT:  op = OP_RECVBIT;
         OP_ACK:      op = OP_ACK;
         default:     op = OP_NONE;
      endcase
   end

   always_comb begin
      cmd.op     = op;
      cmd.sda_in = req_if.sda_in;
      // Receives shift in from an empty register.
      if (op == OP_RECVBYTE || op == OP_RECVBIT) begin
         cmd.shift_init = '0;
      end else begin
         cmd.shift_init = req_if.data_byte;
      end
   end

   assign cmd_valid    = req_if.valid;
   assign req_if.ready = cmd_ready;

endmodule

FILE: design/i2cbb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-bang command queue
// Short FIFO between the front end and the pin sequencer so that either
// side can stall without stopping the other at once.
// ----------------------------------------------------------------------------
module i2cbb_queue import i2cbb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type push_cmd,
   input  logic    push_valid,
   output logic    push_ready,
   output cmd_type pop_cmd,
   output logic    pop_valid,
   input  logic    pop_ready
);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]  count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign push_ready = (count_ff != QCNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QPTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QPTR_WIDTH'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: design/i2cbb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-bang pin sequencer
// Runs one tick per queued item: starts commands, times each SCL/SDA phase,
// samples SDA on receives and registers the per-tick result.
// ----------------------------------------------------------------------------
module i2cbb_back import i2cbb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [DELAY_WIDTH-1:0] csr_wdata,
   input  cmd_type                cmd,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   i2cbb_rsp_if.source            rsp_if
);

   localparam pin_type PIN_RESET = '{scl: 1'b1, sda: SDA_HIGH};

   op_type                   op_ff, op_in, op_a;
   logic [1:0]               phase_ff, phase_in, phase_a;
   logic [DELAY_WIDTH-1:0]   tick_ff, tick_in, tick_a;
   logic [BIT_CNT_WIDTH-1:0] bit_ff, bit_in, bit_a, bit_n, units;
   logic [DATA_WIDTH-1:0]    sh_ff, sh_in, sh_a;
   pin_type                  pin_ff, pin_in, pin_a;
   logic [DELAY_WIDTH-1:0]   delay_ff, delay_in, dly;
   logic [DELAY_WIDTH:0]     tick_inc;
   logic                     started, fin_a, fin_b, is_recv, unit_end;
   logic [1:0]               last_phase;
   op_type                   op_seen;
   logic                     step;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   // Pin levels of one phase of a command.
   function automatic pin_type pins_of(op_type op, logic [1:0] phase,
                                       logic [DATA_WIDTH-1:0] sh,
                                       logic [BIT_CNT_WIDTH-1:0] bitcnt);
      pin_type                  p;
      logic                     d;
      logic [BIT_CNT_WIDTH-1:0] pos;
      pos = BIT_CNT_WIDTH'(BITS_PER_BYTE - 1) - bitcnt;
      d   = sh[0];
      if (op == OP_SENDBYTE) begin
         // Bytes go out MSB first; positions above the register send zero.
         d = (pos < BIT_CNT_WIDTH'(DATA_WIDTH)) ? sh[pos[DATA_IDX_WIDTH-1:0]] : 1'b0;
      end
      unique case (op)
         OP_IDLE: begin
            p = '{scl: 1'b1, sda: SDA_HIGH};
         end
         OP_START: begin
            p = '{scl: 1'b1, sda: (phase == 2'd0) ? SDA_HIGH : SDA_LOW};
         end
         OP_STOP: begin
            p = '{scl: 1'b1, sda: (phase == 2'd0) ? SDA_LOW : SDA_HIGH};
         end
         OP_SENDBYTE, OP_SENDBIT, OP_ACK: begin
            p = '{scl: (phase == 2'd1), sda: d ? SDA_HIGH : SDA_LOW};
         end
         default: begin
            p = '{scl: (phase == 2'd1), sda: SDA_REL};
         end
      endcase
      return p;
   endfunction

   assign cmd_ready = !rsp_valid_ff || rsp_if.ready;
   assign step      = cmd_valid && cmd_ready;
   assign dly       = (delay_ff == '0) ? DELAY_WIDTH'(1) : delay_ff;

   // Command entry: a new command is taken only between commands.
   always_comb begin
      op_a    = op_ff;
      phase_a = phase_ff;
      tick_a  = tick_ff;
      bit_a   = bit_ff;
      sh_a    = sh_ff;
      pin_a   = pin_ff;
      started = 1'b0;
      fin_a   = 1'b0;
      if (op_ff == OP_NONE && cmd.op != OP_NONE) begin
         started = 1'b1;
         phase_a = '0;
         tick_a  = '0;
         bit_a   = '0;
         sh_a    = cmd.shift_init;
         pin_a   = pins_of(cmd.op, 2'd0, cmd.shift_init, '0);
         if (cmd.op == OP_IDLE) begin
            // Idle has a single untimed phase and ends on the spot.
            op_a  = OP_NONE;
            fin_a = 1'b1;
         end else begin
            op_a = cmd.op;
         end
      end
   end

   // Next state: count the tick and move through the phase list.
   always_comb begin
      op_in      = op_a;
      phase_in   = phase_a;
      tick_in    = tick_a;
      bit_in     = bit_a;
      sh_in      = sh_a;
      pin_in     = pin_a;
      fin_b      = 1'b0;
      is_recv    = (op_a == OP_RECVBYTE) || (op_a == OP_RECVBIT);
      units      = (op_a == OP_SENDBYTE || op_a == OP_RECVBYTE) ?
                   BIT_CNT_WIDTH'(BITS_PER_BYTE) : BIT_CNT_WIDTH'(1);
      last_phase = (op_a == OP_START || op_a == OP_STOP || op_a == OP_ACK) ?
                   2'd1 : 2'd2;
      bit_n      = bit_a + BIT_CNT_WIDTH'(1);
      tick_inc   = {1'b0, tick_a} + (DELAY_WIDTH + 1)'(1);
      unit_end   = 1'b0;
      if (!fin_a && op_a != OP_NONE) begin
         if (is_recv && phase_a == 2'd1 && tick_a == '0) begin
            sh_in = {sh_a[DATA_WIDTH-2:0], cmd.sda_in};
         end
         if (tick_inc >= {1'b0, dly}) begin
            tick_in = '0;
            // The SCL-low phase after a received bit is untimed.
            if (is_recv && phase_a == 2'd1) begin
               pin_in   = pins_of(op_a, 2'd2, sh_in, bit_a);
               unit_end = 1'b1;
            end else if (phase_a == last_phase) begin
               unit_end = 1'b1;
            end else begin
               phase_in = phase_a + 2'd1;
               pin_in   = pins_of(op_a, phase_a + 2'd1, sh_in, bit_a);
            end
            if (unit_end) begin
               phase_in = '0;
               if (bit_n >= units) begin
                  op_in  = OP_NONE;
                  bit_in = '0;
                  fin_b  = 1'b1;
               end else begin
                  bit_in = bit_n;
                  pin_in = pins_of(op_a, 2'd0, sh_in, bit_n);
               end
            end
         end else begin
            tick_in = tick_inc[DELAY_WIDTH-1:0];
         end
      end
   end

   // Result of this tick.
   always_comb begin
      op_seen          = started ? cmd.op : op_ff;
      rsp_in.scl_out   = pin_a.scl;
      rsp_in.sda_mode  = pin_a.sda;
      rsp_in.busy_res  = started || (op_ff != OP_NONE);
      rsp_in.done_res  = fin_a || fin_b;
      rsp_in.read_data = '0;
      if ((fin_a || fin_b) && (op_seen == OP_RECVBYTE || op_seen == OP_RECVBIT)) begin
         rsp_in.read_data = sh_in;
      end
   end

   always_comb begin
      delay_in     = csr_we ? csr_wdata : delay_ff;
      rsp_valid_in = step ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= OP_NONE;
         phase_ff     <= '0;
         tick_ff      <= '0;
         bit_ff       <= '0;
         sh_ff        <= '0;
         pin_ff       <= PIN_RESET;
         delay_ff     <= DELAY_WIDTH'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            op_ff    <= op_in;
            phase_ff <= phase_in;
            tick_ff  <= tick_in;
            bit_ff   <= bit_in;
            sh_ff    <= sh_in;
            pin_ff   <= pin_in;
         end
         delay_ff     <= delay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.scl_out   = rsp_ff.scl_out;
   assign rsp_if.sda_mode  = rsp_ff.sda_mode;
   assign rsp_if.busy_res  = rsp_ff.busy_res;
   assign rsp_if.done_res  = rsp_ff.done_res;
   assign rsp_if.read_data = rsp_ff.read_data;

endmodule

FILE: design/i2c_bitbang_master_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-bang master sequencer
// Software-timed I2C master pin sequencer, one request transfer per tick.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on req_if is one tick of the pin sequencer. It carries a
// command code (taken only while no command runs), the byte to send and the
// sampled SDA level. Every request yields exactly one transfer on rsp_if with
// the SCL level, the SDA drive mode, busy, a one-tick done pulse and the
// received byte on the done tick of a receive.
// csr_we/csr_wdata write the phase length in ticks (zero acts as one); write
// it only while no command is running and all responses are drained.
// A request is held in the four-entry queue and then in the sequencer step,
// which loads the response register that drives rsp_if. One request is taken
// every cycle while the queue is not full.
// When rsp_if stalls, the response register holds and the queue fills; once
// it holds four requests req_if.ready drops until responses drain.
// Reset empties the queue, sets the phase length to one tick and leaves SCL
// high with SDA driven high and no command active.
// ----------------------------------------------------------------------------
module i2c_bitbang_master_sequencer import i2cbb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   i2cbb_req_if.sink              req_if,
   i2cbb_rsp_if.source            rsp_if,
   input  logic                   csr_we,
   input  logic [DELAY_WIDTH-1:0] csr_wdata
);

   cmd_type fe_cmd;
   logic    fe_valid;
   logic    fe_ready;
   cmd_type q_cmd;
   logic    q_valid;
   logic    q_ready;

   i2cbb_front u_front (
      .req_if    (req_if),
      .cmd       (fe_cmd),
      .cmd_valid (fe_valid),
      .cmd_ready (fe_ready)
   );

   i2cbb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (fe_cmd),
      .push_valid (fe_valid),
      .push_ready (fe_ready),
      .pop_cmd    (q_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready)
   );

   i2cbb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (q_cmd),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .rsp_if    (rsp_if)
   );

`ifndef SYNTHESIS
   // Every tick taken from the queue shows up as a response in the next cycle.
   a_step_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |=> rsp_if.valid)
      else $error("queued tick did not produce a response");

   // A stalled response must block the sequencer from taking another tick.
   a_stall_blocks_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |-> !(q_valid && q_ready))
      else $error("sequencer stepped while its response was stalled");

   // A command can only finish on a tick that it occupies.
   a_done_is_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.done_res) |-> rsp_if.busy_res)
      else $error("done reported on a tick without a command");
`endif

endmodule

FILE: tb/i2cbb_tick_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-bang sequencer tick checker
// Watches the request and response channels and the phase length register.
// It keeps its own copy of the pin sequencer state and works out the pins and
// status of every request transfer. Each response transfer is then compared,
// field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module i2cbb_tick_checker import i2cbb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   i2cbb_req_if                   req_mon,
   i2cbb_rsp_if                   rsp_mon,
   input  logic                   csr_we,
   input  logic [DELAY_WIDTH-1:0] csr_wdata,
   output logic                   seq_idle,
   output int                     pending,
   output int                     fail_count
);

   logic [DELAY_WIDTH-1:0] phase_len;
   op_type                 cur_op;
   int                     phase_idx;
   int                     tick_cnt;
   int                     bit_cnt;
   logic [DATA_WIDTH-1:0]  shreg;
   logic                   pin_scl;
   sda_type                pin_sda;

   rsp_type                due_ticks[$];
   rsp_type                want;

   initial fail_count = 0;

   function automatic int units_for(op_type o);
      if (o == OP_SENDBYTE || o == OP_RECVBYTE) return BITS_PER_BYTE;
      return 1;
   endfunction

   function automatic int phases_for(op_type o);
      if (o == OP_IDLE) return 1;
      if (o == OP_START || o == OP_STOP || o == OP_ACK) return 2;
      return 3;
   endfunction

   // Bytes go out MSB first; single bits and acks use bit 0.
   function automatic logic tx_bit();
      int pos;
      if (cur_op != OP_SENDBYTE) return shreg[0];
      pos = BITS_PER_BYTE - 1 - bit_cnt;
      if (pos >= DATA_WIDTH) return 1'b0;
      return shreg[pos];
   endfunction

   function automatic void phase_pins(output logic scl, output sda_type sda,
                                      output logic timed, output logic sample);
      timed  = 1'b1;
      sample = 1'b0;
      case (cur_op)
         OP_IDLE: begin
            scl   = 1'b1;
            sda   = SDA_HIGH;
            timed = 1'b0;
         end
         OP_START: begin
            scl = 1'b1;
            sda = (phase_idx == 0) ? SDA_HIGH : SDA_LOW;
         end
         OP_STOP: begin
            scl = 1'b1;
            sda = (phase_idx == 0) ? SDA_LOW : SDA_HIGH;
         end
         OP_SENDBYTE, OP_SENDBIT, OP_ACK: begin
            scl = (phase_idx == 1);
            sda = tx_bit() ? SDA_HIGH : SDA_LOW;
         end
         default: begin
            // The last SCL-low phase of a received bit has no hold time.
            scl    = (phase_idx == 1);
            sda    = SDA_REL;
            sample = (phase_idx == 1);
            timed  = (phase_idx != 2);
         end
      endcase
   endfunction

   function automatic void next_phase();
      phase_idx++;
      if (phase_idx >= phases_for(cur_op)) begin
         phase_idx = 0;
         bit_cnt++;
      end
   endfunction

   // Loads the current phase, skipping on past untimed ones, and returns 1 when
   // the command has no phases left.
   function automatic logic load_phase();
      logic    scl, timed, sample, fin, stop;
      sda_type sda;
      fin  = 1'b0;
      stop = 1'b0;
      while (!stop) begin
         if (bit_cnt >= units_for(cur_op)) begin
            cur_op    = OP_NONE;
            phase_idx = 0;
            tick_cnt  = 0;
            bit_cnt   = 0;
            fin       = 1'b1;
            stop      = 1'b1;
         end else begin
            phase_pins(scl, sda, timed, sample);
            pin_scl = scl;
            pin_sda = sda;
            if (timed) begin
               tick_cnt = 0;
               stop     = 1'b1;
            end else begin
               next_phase();
            end
         end
      end
      return fin;
   endfunction

   function automatic rsp_type predict_tick(logic [FUNC_WIDTH-1:0] func,
                                            logic [DATA_WIDTH-1:0] data,
                                            logic sda_in);
      rsp_type r;
      logic    scl, timed, sample, fin;
      sda_type sda;
      op_type  seen;
      int      dly;
      dly         = (phase_len == '0) ? 1 : int'(phase_len);
      r           = '0;
      r.scl_out   = pin_scl;
      r.sda_mode  = pin_sda;
      seen        = cur_op;
      fin         = 1'b0;
      if (cur_op == OP_NONE && func >= OP_IDLE && func <= OP_ACK) begin
         cur_op     = op_type'(func);
         seen       = cur_op;
         phase_idx  = 0;
         tick_cnt   = 0;
         bit_cnt    = 0;
         shreg      = (cur_op == OP_RECVBYTE || cur_op == OP_RECVBIT) ? '0 : data;
         r.busy_res = 1'b1;
         fin        = load_phase();
         r.scl_out  = pin_scl;
         r.sda_mode = pin_sda;
      end
      if (!fin && cur_op != OP_NONE) begin
         r.busy_res = 1'b1;
         r.scl_out  = pin_scl;
         r.sda_mode = pin_sda;
         phase_pins(scl, sda, timed, sample);
         // SDA is taken on the first tick of the SCL-high phase only.
         if (sample && tick_cnt == 0) shreg = {shreg[DATA_WIDTH-2:0], sda_in};
         tick_cnt++;
         if (tick_cnt >= dly) begin
            next_phase();
            fin = load_phase();
         end
      end
      if (fin) begin
         r.done_res = 1'b1;
         if (seen == OP_RECVBYTE || seen == OP_RECVBIT) r.read_data = shreg;
      end
      return r;
   endfunction

   task automatic flag_field(input string field, input logic [7:0] exp_val,
                             input logic [7:0] got_val);
      if (got_val !== exp_val) begin
         fail_count++;
         $error("%s: expected %0h, got %0h", field, exp_val, got_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase_len = 1;
         cur_op    = OP_NONE;
         phase_idx = 0;
         tick_cnt  = 0;
         bit_cnt   = 0;
         shreg     = '0;
         pin_scl   = 1'b1;
         pin_sda   = SDA_HIGH;
         due_ticks.delete();
      end else begin
         if (csr_we) phase_len = csr_wdata;
         // Responses are matched before this edge's request is queued, so a
         // stray response can never pair with a prediction made just now.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_ticks.size() == 0) begin
               fail_count++;
               $error("response transfer with no request waiting");
            end else begin
               want = due_ticks.pop_front();
               flag_field("scl_out", 8'(want.scl_out), 8'(rsp_mon.scl_out));
               flag_field("sda_mode", 8'(want.sda_mode), 8'(rsp_mon.sda_mode));
               flag_field("busy_res", 8'(want.busy_res), 8'(rsp_mon.busy_res));
               flag_field("done_res", 8'(want.done_res), 8'(rsp_mon.done_res));
               flag_field("read_data", want.read_data, rsp_mon.read_data);
            end
         end
         if (req_mon.valid && req_mon.ready)
            due_ticks.push_back(predict_tick(req_mon.func, req_mon.data_byte,
                                             req_mon.sda_in));
      end
      seq_idle <= (cur_op == OP_NONE);
      pending  <= due_ticks.size();
   end

endmodule

FILE: tb/tb_i2c_bitbang_master_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-bang master sequencer testbench
// Drives sequencer ticks with commands, data and SDA levels, first a directed
// pass over every command and pin case, then random streams under several
// phase lengths, with random gaps and stalls on both channels. The checker
// beside the block predicts and compares every response transfer.
// ----------------------------------------------------------------------------
module tb_i2c_bitbang_master_sequencer import i2cbb_pkg::*; ();

   localparam int CYCLE_LIMIT   = 50000;
   localparam int RAND_PHASES   = 6;
   localparam int ITEMS_PER_RUN = 15;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [DELAY_WIDTH-1:0] csr_wdata;
   logic                   seq_idle;
   int                     pending;
   int                     fail_count;
   int                     gap_max   = 5;
   int                     stall_max = 5;
   int                     cycles    = 0;

   i2cbb_req_if req ();
   i2cbb_rsp_if rsp ();

   i2c_bitbang_master_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req),
      .rsp_if    (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   i2cbb_tick_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req),
      .rsp_mon    (rsp),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .seq_idle   (seq_idle),
      .pending    (pending),
      .fail_count (fail_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Response side: a random stall before each transfer.
   initial begin
      int stall;
      rsp.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = $urandom_range(0, stall_max);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   function automatic logic pick_sda(input int sel);
      if (sel == 0) return 1'b0;
      if (sel == 1) return 1'b1;
      return 1'($urandom_range(0, 1));
   endfunction

   // Mostly real commands, some no-ops and some unknown codes.
   function automatic logic [FUNC_WIDTH-1:0] pick_func();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return FUNC_WIDTH'($urandom_range(OP_IDLE, OP_ACK));
      if (r < 85) return OP_NONE;
      return FUNC_WIDTH'($urandom_range(OP_ACK + 1, 15));
   endfunction

   // Valid stays high from one transfer to the next when no gap is drawn.
   task automatic send_tick(input logic [FUNC_WIDTH-1:0] f,
                            input logic [DATA_WIDTH-1:0] d, input logic s);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.func      <= f;
      req.data_byte <= d;
      req.sda_in    <= s;
      do @(posedge clock); while (!req.ready);
   endtask

   // The idle flag trails by one transfer, so at most one extra no-op goes out.
   task automatic finish_command(input int sda_sel);
      do send_tick(OP_NONE, DATA_WIDTH'($urandom_range(0, 255)), pick_sda(sda_sel));
      while (!seq_idle);
   endtask

   task automatic run_cmd(input logic [FUNC_WIDTH-1:0] f,
                          input logic [DATA_WIDTH-1:0] d, input int sda_sel);
      send_tick(f, d, pick_sda(sda_sel));
      finish_command(sda_sel);
   endtask

   task automatic write_phase_len(input logic [DELAY_WIDTH-1:0] v);
      finish_command(2);
      req.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int p, i;
      reset         <= 1'b1;
      req.valid     <= 1'b0;
      req.func      <= OP_NONE;
      req.data_byte <= '0;
      req.sda_in    <= 1'b0;
      csr_we        <= 1'b0;
      csr_wdata     <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset pins, unknown codes, then every command at the reset phase length.
      send_tick(OP_NONE, 8'h00, 1'b0);
      send_tick(4'hF, 8'hFF, 1'b1);
      send_tick(4'h9, 8'h5A, 1'b0);
      run_cmd(OP_IDLE, 8'h00, 2);
      run_cmd(OP_START, 8'h00, 2);
      run_cmd(OP_SENDBYTE, 8'hFF, 2);
      run_cmd(OP_SENDBYTE, 8'h00, 2);
      run_cmd(OP_SENDBYTE, 8'hA5, 2);
      run_cmd(OP_RECVBYTE, 8'h00, 1);
      run_cmd(OP_RECVBYTE, 8'hFF, 0);
      run_cmd(OP_RECVBYTE, 8'h3C, 2);
      run_cmd(OP_SENDBIT, 8'h01, 2);
      run_cmd(OP_SENDBIT, 8'hFE, 2);
      run_cmd(OP_RECVBIT, 8'h00, 1);
      run_cmd(OP_RECVBIT, 8'hFF, 0);
      run_cmd(OP_ACK, 8'h00, 2);
      run_cmd(OP_ACK, 8'hFF, 2);
      // Commands that arrive while one is running must be ignored.
      send_tick(OP_START, 8'h00, 1'b1);
      send_tick(OP_SENDBYTE, 8'hC3, 1'b0);
      send_tick(OP_RECVBYTE, 8'h00, 1'b1);
      finish_command(2);
      run_cmd(OP_STOP, 8'h00, 2);

      // A zero phase length acts as one tick.
      write_phase_len('0);
      run_cmd(OP_START, 8'h00, 2);
      run_cmd(OP_SENDBYTE, 8'h96, 2);
      run_cmd(OP_RECVBIT, 8'h00, 2);
      run_cmd(OP_RECVBYTE, 8'h00, 2);
      run_cmd(OP_STOP, 8'h00, 2);

      // A longer phase length on a short command, without gaps or stalls.
      gap_max   = 0;
      stall_max = 0;
      write_phase_len(DELAY_WIDTH'(20));
      run_cmd(OP_START, 8'h00, 2);

      for (p = 0; p < RAND_PHASES; p++) begin
         gap_max   = $urandom_range(0, 1) ? 5 : 0;
         stall_max = $urandom_range(0, 1) ? 5 : 0;
         write_phase_len(DELAY_WIDTH'($urandom_range(0, 4)));
         for (i = 0; i < ITEMS_PER_RUN; i++)
            send_tick(pick_func(), DATA_WIDTH'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
      end

      req.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: files.f
design/i2cbb_pkg.sv
design/i2cbb_req_if.sv
design/i2cbb_rsp_if.sv
design/i2cbb_front.sv
design/i2cbb_queue.sv
design/i2cbb_back.sv
design/i2c_bitbang_master_sequencer.sv
tb/i2cbb_tick_checker.sv
tb/tb_i2c_bitbang_master_sequencer.sv
